@@ design/qmr_pkg.sv @@
// ----------------------------------------------------------------------------
// qmr_pkg: shared types and constants for the quaternion unit
// Fixed-point format, command codes, term sign masks and small helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package qmr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int Q_W       = 32;
  localparam int PROD_W    = 2 * Q_W;
  localparam int TERM_W    = PROD_W - FRAC_BITS;
  localparam int SUM_W     = TERM_W + 2;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  typedef logic signed [Q_W-1:0] q_t;

  localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_MUL  = 2'd0,
    CMD_CONJ = 2'd1,
    CMD_ROT  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic mul;
    logic sum;
  } stage_en_t;

  typedef struct packed {
    q_t   val;
    logic ovf;
  } sat_q_t;

  // Subtracted terms of each Hamilton component, bit k = term p[k]*r[c^k]
  localparam logic [3:0] HAM_SUB [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  function automatic logic [1:0] ham_idx(input int c, input int k);
    ham_idx = 2'(c) ^ 2'(k);
  endfunction

  function automatic sat_q_t neg_sat(input q_t v);
    sat_q_t r;
    if (v == Q_MIN) begin
      r.val = Q_MAX;
      r.ovf = 1'b1;
    end else begin
      r.val = -v;
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/qmr_lane.sv @@
// ----------------------------------------------------------------------------
// qmr_lane: one Hamilton component
// Four registered products, then round, signed sum and saturation to Q_W.
// ----------------------------------------------------------------------------
`default_nettype none

module qmr_lane import qmr_pkg::*; (
  input  logic       clk,
  input  stage_en_t  en,
  input  q_t         x [4],
  input  q_t         y [4],
  input  logic [3:0] neg,
  input  logic [3:0] sub,
  output q_t         sum,
  output logic       ovf
);

  logic signed [PROD_W-1:0] prod [4];
  logic [3:0]               neg_q;
  logic [3:0]               sub_q;
  q_t                       sum_next;
  logic                     ovf_next;

  always_ff @(posedge clk) begin
    if (en.mul) begin
      for (int k = 0; k < 4; k++) begin
        prod[k] <= x[k] * y[k];
      end
      neg_q <= neg;
      sub_q <= sub;
    end
  end

  always_comb begin
    logic signed [PROD_W-1:0] pn;
    logic signed [PROD_W-1:0] rs;
    logic signed [SUM_W-1:0]  term;
    logic signed [SUM_W-1:0]  acc;
    logic [SUM_W-Q_W:0]       hi;
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      pn   = neg_q[k] ? -prod[k] : prod[k];
      rs   = pn + ROUND_HALF;
      term = SUM_W'(signed'(rs[PROD_W-1:FRAC_BITS]));
      acc  = sub_q[k] ? acc - term : acc + term;
    end
    hi = acc[SUM_W-1:Q_W-1];
    if ((&hi) || !(|hi)) begin
      sum_next = acc[Q_W-1:0];
      ovf_next = 1'b0;
    end else begin
      sum_next = acc[SUM_W-1] ? Q_MIN : Q_MAX;
      ovf_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      sum <= sum_next;
      ovf <= ovf_next;
    end
  end

endmodule

`default_nettype wire

@@ design/qmr_hamilton.sv @@
// ----------------------------------------------------------------------------
// qmr_hamilton: Hamilton product p*r over four parallel lanes
// Optional negation of the vector part of r (conjugate) folded into products.
// ----------------------------------------------------------------------------
`default_nettype none

module qmr_hamilton import qmr_pkg::*; (
  input  logic      clk,
  input  stage_en_t en,
  input  q_t        p [4],
  input  q_t        r [4],
  input  logic      conj_r,
  output q_t        s [4],
  output logic      f [4]
);

  for (genvar c = 0; c < 4; c++) begin : g_lane
    q_t         y [4];
    logic [3:0] neg;

    for (genvar k = 0; k < 4; k++) begin : g_term
      assign y[k]   = r[ham_idx(c, k)];
      assign neg[k] = conj_r && (ham_idx(c, k) != 2'd0);
    end

    qmr_lane u_lane (
      .clk (clk),
      .en  (en),
      .x   (p),
      .y   (y),
      .neg (neg),
      .sub (HAM_SUB[c]),
      .sum (s[c]),
      .ovf (f[c])
    );
  end

endmodule

`default_nettype wire

@@ design/quaternion_multiply_rotate_unit.sv @@
// ----------------------------------------------------------------------------
// quaternion_multiply_rotate_unit: Q16.16 quaternion multiply/conjugate/rotate
//
// Input channel: in_valid/in_stall carry command and quaternions a and b.
// Output channel: out_valid/out_stall carry out_w..out_z and overflow.
// A request is taken on a clock edge with valid high and stall low.
// Commands: multiply a*b, conjugate a, rotate vector (b_x,b_y,b_z) by a.
// One request per cycle is sustained while out_stall is low. Two Hamilton
// units in series (four lanes each, one per component) set the pipeline
// depth: the first forms a*b or v*conj(a), the second a*mid for rotate.
// Each stage holds its contents while the next one is full and stalled,
// so empty slots still fill while a result waits; in_stall rises only
// when all four stages are occupied and out_stall is high.
// Synchronous reset empties the pipeline; no other state is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_multiply_rotate_unit import qmr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  q_t         a_w,
  input  q_t         a_x,
  input  q_t         a_y,
  input  q_t         a_z,
  input  q_t         b_w,
  input  q_t         b_x,
  input  q_t         b_y,
  input  q_t         b_z,
  output logic       out_valid,
  input  logic       out_stall,
  output q_t         out_w,
  output q_t         out_x,
  output q_t         out_y,
  output q_t         out_z,
  output logic       overflow
);

  logic [4:1] vld;
  logic [4:1] rdy;
  cmd_t       cmd_in;
  cmd_t       cmd1, cmd2, cmd3, cmd4;
  q_t         a_in [4];
  q_t         b_in [4];
  q_t         a1 [4];
  q_t         a2 [4];
  q_t         conj_in [4];
  q_t         conj1 [4];
  q_t         conj2 [4];
  logic       cf_in, cf1, cf2;
  q_t         pa [4];
  q_t         ra [4];
  q_t         sa [4];
  logic       fa [4];
  q_t         res2 [4];
  logic       flag2;
  q_t         res3 [4];
  q_t         res4 [4];
  logic       flag3, flag4;
  q_t         sb [4];
  logic       fb [4];
  stage_en_t  en_a, en_b;

  assign rdy[4]   = !vld[4] || !out_stall;
  assign rdy[3]   = !vld[3] || rdy[4];
  assign rdy[2]   = !vld[2] || rdy[3];
  assign rdy[1]   = !vld[1] || rdy[2];
  assign in_stall = !rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= in_valid;
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
      if (rdy[4]) vld[4] <= vld[3];
    end
  end

  assign cmd_in = cmd_t'(command);
  assign a_in   = '{a_w, a_x, a_y, a_z};
  assign b_in   = '{b_w, b_x, b_y, b_z};

  // conjugate of a, vector part negated with saturation
  always_comb begin
    sat_q_t nx, ny, nz;
    nx = neg_sat(a_x);
    ny = neg_sat(a_y);
    nz = neg_sat(a_z);
    conj_in = '{a_w, nx.val, ny.val, nz.val};
    cf_in   = nx.ovf | ny.ovf | nz.ovf;
  end

  // rotate: first product is (0,v)*conj(a)
  always_comb begin
    if (cmd_in == CMD_ROT) begin
      pa = '{'0, b_x, b_y, b_z};
      ra = a_in;
    end else begin
      pa = a_in;
      ra = b_in;
    end
  end

  assign en_a = '{mul: rdy[1], sum: rdy[2]};
  assign en_b = '{mul: rdy[3], sum: rdy[4]};

  qmr_hamilton u_ham_a (
    .clk    (clk),
    .en     (en_a),
    .p      (pa),
    .r      (ra),
    .conj_r (cmd_in == CMD_ROT),
    .s      (sa),
    .f      (fa)
  );

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      cmd1  <= cmd_in;
      a1    <= a_in;
      conj1 <= conj_in;
      cf1   <= cf_in;
    end
    if (rdy[2]) begin
      cmd2  <= cmd1;
      a2    <= a1;
      conj2 <= conj1;
      cf2   <= cf1;
    end
  end

  // merge of first-stage lanes
  always_comb begin
    unique case (cmd2)
      CMD_MUL, CMD_ROT: begin
        res2  = sa;
        flag2 = fa[0] | fa[1] | fa[2] | fa[3];
      end
      CMD_CONJ: begin
        res2  = conj2;
        flag2 = cf2;
      end
      default: begin
        res2  = '{'0, '0, '0, '0};
        flag2 = 1'b0;
      end
    endcase
  end

  qmr_hamilton u_ham_b (
    .clk    (clk),
    .en     (en_b),
    .p      (a2),
    .r      (res2),
    .conj_r (1'b0),
    .s      (sb),
    .f      (fb)
  );

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      cmd3  <= cmd2;
      res3  <= res2;
      flag3 <= flag2;
    end
    if (rdy[4]) begin
      cmd4  <= cmd3;
      res4  <= res3;
      flag4 <= flag3;
    end
  end

  // final merge; rotate drops the scalar part and its flag
  always_comb begin
    if (cmd4 == CMD_ROT) begin
      out_w    = '0;
      out_x    = sb[1];
      out_y    = sb[2];
      out_z    = sb[3];
      overflow = flag4 | fb[1] | fb[2] | fb[3];
    end else begin
      out_w    = res4[0];
      out_x    = res4[1];
      out_y    = res4[2];
      out_z    = res4[3];
      overflow = flag4;
    end
  end

  assign out_valid = vld[4];

endmodule

`default_nettype wire

@@ test/quaternion_multiply_rotate_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_multiply_rotate_unit_tb: self-checking bench for the quaternion unit
// Directed corner requests, then ~1130 random requests, are sent with bursty
// valid while the result side stalls on its own pattern. Every request that
// is taken is predicted in Q16.16 and results are checked in order.
// ----------------------------------------------------------------------------

module quaternion_multiply_rotate_unit_tb;
  import qmr_pkg::*;

  localparam int  IDLE_LIMIT = 2000;
  localparam int  N_RANDOM   = 1130;
  localparam q_t  ONE        = 32'sh0001_0000;

  typedef struct packed {
    cmd_t cmd;
    q_t   a_w, a_x, a_y, a_z;
    q_t   b_w, b_x, b_y, b_z;
  } quat_req_t;

  typedef struct packed {
    q_t   w, x, y, z;
    logic ovf;
  } quat_res_t;

  typedef struct packed {
    longint w, x, y, z;
  } quat_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      out_stall = 1'b0;
  quat_req_t cur_req = '0;
  logic      in_stall, out_valid, overflow;
  q_t        out_w, out_x, out_y, out_z;

  quat_req_t request_q[$];
  quat_res_t quat_due_q[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        burst_left = 0, gap_left = 0;
  int        recv_mode = 0, recv_left = 0, stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quaternion_multiply_rotate_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (cur_req.cmd),
    .a_w       (cur_req.a_w),
    .a_x       (cur_req.a_x),
    .a_y       (cur_req.a_y),
    .a_z       (cur_req.a_z),
    .b_w       (cur_req.b_w),
    .b_x       (cur_req.b_x),
    .b_y       (cur_req.b_y),
    .b_z       (cur_req.b_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_w     (out_w),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .overflow  (overflow)
  );

  // ---- prediction ----------------------------------------------------------

  // rounded to nearest, ties toward plus infinity
  function automatic longint fx_mul(longint p, longint r);
    return (p * r + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic out_of_q(longint v);
    return (v > longint'(Q_MAX)) || (v < longint'(Q_MIN));
  endfunction

  function automatic longint clamp_q(longint v);
    longint r;
    r = v;
    if (v > longint'(Q_MAX)) r = longint'(Q_MAX);
    if (v < longint'(Q_MIN)) r = longint'(Q_MIN);
    return r;
  endfunction

  // saturated Hamilton product; sat[0] is w .. sat[3] is z
  function automatic quat_t hamilton(quat_t p, quat_t r, output logic [3:0] sat);
    quat_t s, o;
    s.w = fx_mul(p.w, r.w) - fx_mul(p.x, r.x) - fx_mul(p.y, r.y) - fx_mul(p.z, r.z);
    s.x = fx_mul(p.w, r.x) + fx_mul(p.x, r.w) + fx_mul(p.y, r.z) - fx_mul(p.z, r.y);
    s.y = fx_mul(p.w, r.y) - fx_mul(p.x, r.z) + fx_mul(p.y, r.w) + fx_mul(p.z, r.x);
    s.z = fx_mul(p.w, r.z) + fx_mul(p.x, r.y) - fx_mul(p.y, r.x) + fx_mul(p.z, r.w);
    sat = {out_of_q(s.z), out_of_q(s.y), out_of_q(s.x), out_of_q(s.w)};
    o.w = clamp_q(s.w);
    o.x = clamp_q(s.x);
    o.y = clamp_q(s.y);
    o.z = clamp_q(s.z);
    return o;
  endfunction

  function automatic quat_res_t quat_result(quat_req_t rq);
    quat_t      a, b, v, ac, mid, o;
    logic [3:0] s1, s2;
    quat_res_t  res;
    a   = '{longint'(rq.a_w), longint'(rq.a_x), longint'(rq.a_y), longint'(rq.a_z)};
    b   = '{longint'(rq.b_w), longint'(rq.b_x), longint'(rq.b_y), longint'(rq.b_z)};
    res = '0;
    case (rq.cmd)
      CMD_MUL: begin
        o   = hamilton(a, b, s1);
        res = '{q_t'(o.w), q_t'(o.x), q_t'(o.y), q_t'(o.z), |s1};
      end
      CMD_CONJ: begin
        res = '{rq.a_w, q_t'(clamp_q(-a.x)), q_t'(clamp_q(-a.y)), q_t'(clamp_q(-a.z)),
                out_of_q(-a.x) | out_of_q(-a.y) | out_of_q(-a.z)};
      end
      CMD_ROT: begin
        v   = '{0, b.x, b.y, b.z};
        ac  = '{a.w, -a.x, -a.y, -a.z};
        mid = hamilton(v, ac, s1);
        o   = hamilton(a, mid, s2);
        // scalar part of the outer product is dropped and never flags
        res = '{'0, q_t'(o.x), q_t'(o.y), q_t'(o.z), (|s1) | (|s2[3:1])};
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  // ---- stimulus helpers ----------------------------------------------------

  task automatic queue_req(cmd_t c, q_t aw, q_t ax, q_t ay, q_t az,
                           q_t bw, q_t bx, q_t by, q_t bz);
    request_q.push_back('{c, aw, ax, ay, az, bw, bx, by, bz});
  endtask

  function automatic q_t rand_q();
    q_t r;
    case ($urandom_range(0, 9))
      0, 1, 2:    r = q_t'($urandom);
      3, 4, 5, 6: r = q_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      7: begin
        case ($urandom_range(0, 6))
          0:       r = Q_MIN;
          1:       r = Q_MAX;
          2:       r = '0;
          3:       r = 32'sd1;
          4:       r = -32'sd1;
          5:       r = ONE;
          default: r = -ONE;
        endcase
      end
      default:    r = q_t'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
    endcase
    return r;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    case ($urandom_range(0, 9))
      0, 1, 2:    c = CMD_MUL;
      3, 4:       c = CMD_CONJ;
      5, 6, 7, 8: c = CMD_ROT;
      default:    c = CMD_NONE;
    endcase
    return c;
  endfunction

  // ---- driver --------------------------------------------------------------

  always @(posedge clk) begin : driver
    quat_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        quat_due_q.push_back(quat_result(cur_req));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          nxt = request_q.pop_front();
          cur_req  <= nxt;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- monitor and result-side stall ---------------------------------------

  always @(posedge clk) begin : monitor
    quat_res_t want, got;
    if (!rst && out_valid && !out_stall) begin
      got = '{out_w, out_x, out_y, out_z, overflow};
      if (quat_due_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with no request pending: %h %h %h %h ovf=%b",
                   $realtime, got.w, got.x, got.y, got.z, got.ovf);
        mismatches <= mismatches + 1;
      end else begin
        want = quat_due_q.pop_front();
        if (got.w !== want.w || got.x !== want.x || got.y !== want.y ||
            got.z !== want.z || got.ovf !== want.ovf) begin
          if (mismatches < 10)
            $display("%0t: mismatch exp %h %h %h %h ovf=%b got %h %h %h %h ovf=%b",
                     $realtime, want.w, want.x, want.y, want.z, want.ovf,
                     got.w, got.x, got.y, got.z, got.ovf);
          mismatches <= mismatches + 1;
        end
      end
    end

    if (recv_left == 0) begin
      recv_mode <= $urandom_range(0, 3);
      recv_left <= $urandom_range(50, 300);
    end else begin
      recv_left <= recv_left - 1;
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case (recv_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: begin
          out_stall  <= ~out_stall;
          stall_left <= $urandom_range(0, 30);
        end
      endcase
    end
  end

  // ---- watchdog ------------------------------------------------------------

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[quaternion_multiply_rotate_unit] ERROR");
        $finish;
      end
    end
  end

  // ---- sequence ------------------------------------------------------------

  initial begin : stimulus
    int n;

    // multiply: identity, zero, extremes, rounding ties both signs
    queue_req(CMD_MUL, ONE, '0, '0, '0, 32'sh0002_8000, -ONE, 32'sh0000_0003, Q_MAX);
    queue_req(CMD_MUL, '0, '0, '0, '0, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    queue_req(CMD_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    queue_req(CMD_MUL, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    queue_req(CMD_MUL, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    queue_req(CMD_MUL, 32'sd1, '0, '0, '0, 32'sh0000_8000, '0, '0, '0);
    queue_req(CMD_MUL, -32'sd1, '0, '0, '0, 32'sh0000_8000, '0, '0, '0);
    queue_req(CMD_MUL, 32'sh0001_8000, -32'sh0000_4000, 32'sh0003_0000, -ONE,
              -32'sh0002_0000, ONE, 32'sh0000_C000, 32'sh0001_1000);
    // conjugate: most negative in each vector lane, and in w (passes through)
    queue_req(CMD_CONJ, ONE, Q_MIN, ONE, -ONE, '0, '0, '0, '0);
    queue_req(CMD_CONJ, ONE, ONE, Q_MIN, -ONE, Q_MAX, '0, '0, '0);
    queue_req(CMD_CONJ, ONE, ONE, -ONE, Q_MIN, '0, Q_MIN, '0, '0);
    queue_req(CMD_CONJ, Q_MIN, Q_MAX, Q_MAX, Q_MAX, '0, '0, '0, '0);
    queue_req(CMD_CONJ, Q_MAX, -32'sd1, 32'sd1, '0, '0, '0, '0, '0);
    // rotate: 90 degrees about z, identity, b_w ignored, saturating middle term
    queue_req(CMD_ROT, 32'sd46341, '0, '0, 32'sd46341, '0, ONE, '0, '0);
    queue_req(CMD_ROT, ONE, '0, '0, '0, Q_MAX, 32'sh0002_0000, -ONE, 32'sh0000_4000);
    queue_req(CMD_ROT, 32'sd46341, 32'sd46341, '0, '0, Q_MIN, '0, ONE, ONE);
    queue_req(CMD_ROT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, '0, Q_MAX, Q_MAX, Q_MAX);
    queue_req(CMD_ROT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
    queue_req(CMD_ROT, 32'sh0000_0100, 32'sh0000_0100, '0, '0, '0, Q_MAX, Q_MIN, Q_MAX);
    // unused command: everything zero
    queue_req(CMD_NONE, Q_MAX, Q_MIN, ONE, -ONE, Q_MAX, Q_MIN, ONE, -ONE);

    for (n = 0; n < N_RANDOM; n++)
      queue_req(rand_cmd(), rand_q(), rand_q(), rand_q(), rand_q(),
                rand_q(), rand_q(), rand_q(), rand_q());

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || in_valid) @(posedge clk);
    while (quat_due_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && quat_due_q.size() == 0)
      $display("[quaternion_multiply_rotate_unit] OK");
    else
      $display("[quaternion_multiply_rotate_unit] ERROR");
    $finish;
  end

endmodule
